FILE: rtl/phc_pkg.sv
// phc_pkg: shared types, register codes, constants and arithmetic helpers
// for the pressure/humidity compensation unit; no dependencies
package phc_pkg;

   localparam int FR_N   = 13;
   localparam int DV_N   = 64;
   localparam int BK_N   = 6;
   localparam int NSTAGE = FR_N + DV_N + BK_N + 1;

   localparam logic [63:0] P_TEMP_BIAS = 64'd128000;
   localparam logic [63:0] P_BASE      = 64'd1048576;
   localparam logic [63:0] P_SCALE     = 64'd3125;
   localparam logic [63:0] P_ONE_47    = 64'h0000_8000_0000_0000;
   localparam logic [31:0] H_BIAS      = 32'd76800;
   localparam logic [31:0] H_W_BIAS    = 32'd2097152;
   localparam logic [31:0] H_CLAMP     = 32'd419430400;

   typedef enum logic [2:0] {
      CSR_CAL_TEMP,
      CSR_CAL_PRESS_A,
      CSR_CAL_PRESS_B,
      CSR_CAL_PRESS_C,
      CSR_CAL_HUM_A,
      CSR_CAL_HUM_B,
      CSR_TEMP_OFFSET,
      CSR_HUM_PRESENT
   } csr_index_type;

   // low 64 bits of a product, split into partial products of its 32-bit halves
   typedef struct packed {
      logic [63:0] lo;
      logic [31:0] mid;
   } mul_pp_type;

   function automatic mul_pp_type mul_pp(input logic [63:0] x, input logic [63:0] y);
      mul_pp_type r;
      r.lo  = {32'b0, x[31:0]} * {32'b0, y[31:0]};
      r.mid = x[63:32] * y[31:0] + x[31:0] * y[63:32];
      return r;
   endfunction

   function automatic logic [63:0] mul_sum(input mul_pp_type p);
      return p.lo + {p.mid, 32'b0};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return $signed(x) >>> n;
   endfunction

endpackage

FILE: rtl/phc_if.sv
// phc_if: valid/ready channels of the compensation unit (sample, result, csr write)
// depends on phc_pkg
interface phc_req_if;
   import phc_pkg::*;
   logic        valid;
   logic        ready;
   logic [19:0] raw_pressure;
   logic [19:0] raw_temperature;
   logic [15:0] raw_humidity;
   modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
   modport sink   (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface phc_rsp_if;
   import phc_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature;
   logic [31:0]        pressure;
   logic [13:0]        humidity;
   logic               humidity_valid;
   logic               fault;
   modport source (output valid, temperature, pressure, humidity, humidity_valid, fault,
                   input ready);
   modport sink   (input valid, temperature, pressure, humidity, humidity_valid, fault,
                   output ready);
endinterface

interface phc_csr_if;
   import phc_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [47:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pressure_humidity_compensation_unit.sv
// pressure_humidity_compensation_unit: integer compensation of raw temperature,
// pressure and humidity codes; depends on phc_pkg and phc_if
//
// One sample beat is accepted per cycle unless the output stalls, and every sample
// gives one result beat (13 front stages for temperature, pressure coefficients and
// humidity, a 64-stage one-bit-per-stage divider for the pressure quotient, 6 back
// stages for the pressure correction, then the output register). A
// one-entry skid register in front of the pipeline keeps the input open for
// one beat while the output is stalled. Calibration writes are always accepted
// and must be made while no sample is in flight.
module pressure_humidity_compensation_unit (
   input logic clock,
   input logic reset,
   phc_req_if.sink   req_ch,
   phc_rsp_if.source rsp_ch,
   phc_csr_if.sink   csr_ch
);
   import phc_pkg::*;

   typedef struct packed {
      logic [19:0] raw_p;
      logic [19:0] raw_t;
      logic [15:0] raw_h;
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] tf;
      logic [15:0] tout;
      logic [63:0] pa;
      logic [63:0] pb;
      logic [63:0] pc;
      mul_pp_type  pl_a;
      mul_pp_type  pl_b;
      mul_pp_type  pl_c;
      logic [31:0] hx;
      logic [31:0] hy;
      logic [31:0] hz;
      logic [13:0] hum;
      logic        neg;
      logic        fault;
   } front_type;

   typedef struct packed {
      logic [63:0] r;
      logic [63:0] nq;
      logic [63:0] d;
      logic        neg;
      logic        fault;
      logic [15:0] tout;
      logic [13:0] hum;
   } div_type;

   typedef struct packed {
      logic [63:0] p;
      logic [63:0] pa;
      logic [63:0] pb;
      mul_pp_type  pl_a;
      mul_pp_type  pl_b;
      logic        fault;
      logic [15:0] tout;
      logic [13:0] hum;
   } back_type;

   typedef struct packed {
      logic [15:0] temperature;
      logic [31:0] pressure;
      logic [13:0] humidity;
      logic        humidity_valid;
      logic        fault;
   } out_type;

   function automatic div_type div_step(input div_type s);
      div_type     o;
      logic [64:0] t;
      logic [64:0] diff;
      o    = s;
      t    = {s.r, s.nq[63]};
      diff = t - {1'b0, s.d};
      o.r  = diff[64] ? t[63:0] : diff[63:0];
      o.nq = {s.nq[62:0], ~diff[64]};
      return o;
   endfunction

   // calibration registers
   logic [47:0] cal_temp_ff, cal_press_a_ff, cal_press_b_ff, cal_press_c_ff;
   logic [31:0] cal_hum_a_ff, cal_hum_b_ff;
   logic [15:0] temp_offset_ff;
   logic        humidity_present_ff;

   // decoded trims
   logic [15:0] t1_c;
   logic [31:0] t2_c, t3_c;
   logic [63:0] p1_c, p2_c, p3_c, p4_c, p5_c, p6_c, p7_c, p8_c, p9_c;
   logic [31:0] h1_c, h2_c, h3_c, h4_c, h5_c, h6_c;

   // skid stage
   logic        skid_vld_ff;
   logic [19:0] skid_p_ff, skid_t_ff;
   logic [15:0] skid_h_ff;
   logic [19:0] src_p, src_t;
   logic [15:0] src_h;
   logic        in_v;
   logic        adv;

   logic [NSTAGE-1:0] pipe_vld_ff, pipe_vld_in;
   front_type fr_ff [1:FR_N];
   front_type fr_in [1:FR_N];
   div_type   dv_ff [1:DV_N];
   div_type   dv_in [1:DV_N];
   div_type   dv_seed;
   back_type  bk_ff [1:BK_N];
   back_type  bk_in [1:BK_N];
   out_type   out_ff, out_in;

   logic [31:0] hv_w, hv3_w, hum_w;
   logic [63:0] pf_w;
   logic        hval_w;

   assign t1_c = cal_temp_ff[15:0];
   assign t2_c = {{16{cal_temp_ff[31]}}, cal_temp_ff[31:16]};
   assign t3_c = {{16{cal_temp_ff[47]}}, cal_temp_ff[47:32]};
   assign p1_c = {48'b0, cal_press_a_ff[15:0]};
   assign p2_c = {{48{cal_press_a_ff[31]}}, cal_press_a_ff[31:16]};
   assign p3_c = {{48{cal_press_a_ff[47]}}, cal_press_a_ff[47:32]};
   assign p4_c = {{48{cal_press_b_ff[15]}}, cal_press_b_ff[15:0]};
   assign p5_c = {{48{cal_press_b_ff[31]}}, cal_press_b_ff[31:16]};
   assign p6_c = {{48{cal_press_b_ff[47]}}, cal_press_b_ff[47:32]};
   assign p7_c = {{48{cal_press_c_ff[15]}}, cal_press_c_ff[15:0]};
   assign p8_c = {{48{cal_press_c_ff[31]}}, cal_press_c_ff[31:16]};
   assign p9_c = {{48{cal_press_c_ff[47]}}, cal_press_c_ff[47:32]};
   assign h1_c = {24'b0, cal_hum_a_ff[7:0]};
   assign h2_c = {{16{cal_hum_a_ff[23]}}, cal_hum_a_ff[23:8]};
   assign h3_c = {24'b0, cal_hum_a_ff[31:24]};
   assign h4_c = {{20{cal_hum_b_ff[11]}}, cal_hum_b_ff[11:0]};
   assign h5_c = {{20{cal_hum_b_ff[23]}}, cal_hum_b_ff[23:12]};
   assign h6_c = {{24{cal_hum_b_ff[31]}}, cal_hum_b_ff[31:24]};

   // handshake
   assign adv          = ~pipe_vld_ff[NSTAGE-1] | rsp_ch.ready;
   assign req_ch.ready = ~skid_vld_ff;
   assign csr_ch.ready = 1'b1;
   assign src_p        = skid_vld_ff ? skid_p_ff : req_ch.raw_pressure;
   assign src_t        = skid_vld_ff ? skid_t_ff : req_ch.raw_temperature;
   assign src_h        = skid_vld_ff ? skid_h_ff : req_ch.raw_humidity;
   assign in_v         = skid_vld_ff | req_ch.valid;
   assign pipe_vld_in  = {pipe_vld_ff[NSTAGE-2:0], in_v};

   // front: temperature, pressure coefficients, humidity
   always_comb begin
      fr_in[1]       = '0;
      fr_in[1].raw_p = src_p;
      fr_in[1].raw_t = src_t;
      fr_in[1].raw_h = src_h;
      fr_in[1].tx    = ({15'b0, src_t[19:3]} - {15'b0, t1_c, 1'b0}) * t2_c;
      fr_in[1].ty    = ({16'b0, src_t[19:4]} - {16'b0, t1_c})
                     * ({16'b0, src_t[19:4]} - {16'b0, t1_c});

      fr_in[2]    = fr_ff[1];
      fr_in[2].tx = asr32(fr_ff[1].tx, 11);
      fr_in[2].ty = asr32(fr_ff[1].ty, 12) * t3_c;

      fr_in[3]    = fr_ff[2];
      fr_in[3].tf = fr_ff[2].tx + asr32(fr_ff[2].ty, 14);

      hv_w          = fr_ff[3].tf - H_BIAS;
      fr_in[4]      = fr_ff[3];
      fr_in[4].tout = 16'(asr32((fr_ff[3].tf << 2) + fr_ff[3].tf + 32'd128, 8))
                    + temp_offset_ff;
      fr_in[4].pa   = {{32{fr_ff[3].tf[31]}}, fr_ff[3].tf} - P_TEMP_BIAS;
      fr_in[4].hx   = h5_c * hv_w;
      fr_in[4].hy   = hv_w * h6_c;
      fr_in[4].hz   = hv_w * h3_c;

      fr_in[5]      = fr_ff[4];
      fr_in[5].pl_a = mul_pp(fr_ff[4].pa, fr_ff[4].pa);
      fr_in[5].pl_b = mul_pp(fr_ff[4].pa, p5_c);
      fr_in[5].pl_c = mul_pp(fr_ff[4].pa, p2_c);
      fr_in[5].hx   = asr32({2'b0, fr_ff[4].raw_h, 14'b0} - (h4_c << 20) - fr_ff[4].hx
                            + 32'd16384, 15);
      fr_in[5].hy   = asr32(fr_ff[4].hy, 10);
      fr_in[5].hz   = asr32(fr_ff[4].hz, 11) + 32'd32768;

      fr_in[6]    = fr_ff[5];
      fr_in[6].pa = mul_sum(fr_ff[5].pl_a);
      fr_in[6].pb = mul_sum(fr_ff[5].pl_b);
      fr_in[6].pc = mul_sum(fr_ff[5].pl_c);
      fr_in[6].hy = fr_ff[5].hy * fr_ff[5].hz;

      fr_in[7]      = fr_ff[6];
      fr_in[7].pl_a = mul_pp(fr_ff[6].pa, p6_c);
      fr_in[7].pl_b = mul_pp(fr_ff[6].pa, p3_c);
      fr_in[7].hz   = (asr32(fr_ff[6].hy, 10) + H_W_BIAS) * h2_c;

      fr_in[8]    = fr_ff[7];
      fr_in[8].pa = mul_sum(fr_ff[7].pl_a) + (fr_ff[7].pb << 17) + (p4_c << 35);
      fr_in[8].pb = asr64(mul_sum(fr_ff[7].pl_b), 8) + (fr_ff[7].pc << 12);
      fr_in[8].hy = fr_ff[7].hx * asr32(fr_ff[7].hz + 32'd8192, 14);

      fr_in[9]      = fr_ff[8];
      fr_in[9].pl_a = mul_pp(P_ONE_47 + fr_ff[8].pb, p1_c);
      fr_in[9].hz   = asr32(fr_ff[8].hy, 15) * asr32(fr_ff[8].hy, 15);

      fr_in[10]    = fr_ff[9];
      fr_in[10].pb = asr64(mul_sum(fr_ff[9].pl_a), 33);
      fr_in[10].pc = ((P_BASE - {44'b0, fr_ff[9].raw_p}) << 31) - fr_ff[9].pa;
      fr_in[10].hz = asr32(fr_ff[9].hz, 7) * h1_c;

      hv3_w          = fr_ff[10].hy - asr32(fr_ff[10].hz, 4);
      fr_in[11]      = fr_ff[10];
      fr_in[11].pl_a = mul_pp(fr_ff[10].pc, P_SCALE);
      if (hv3_w[31]) begin
         fr_in[11].hx = '0;
      end else if (hv3_w > H_CLAMP) begin
         fr_in[11].hx = H_CLAMP;
      end else begin
         fr_in[11].hx = hv3_w;
      end

      hum_w         = {12'b0, fr_ff[11].hx[31:12]} * 32'd100;
      fr_in[12]     = fr_ff[11];
      fr_in[12].pc  = mul_sum(fr_ff[11].pl_a);
      fr_in[12].hum = hum_w[23:10];

      // sign and magnitudes for the divider
      fr_in[13]       = fr_ff[12];
      fr_in[13].neg   = fr_ff[12].pc[63] ^ fr_ff[12].pb[63];
      fr_in[13].fault = (fr_ff[12].pb == '0);
      fr_in[13].pa    = fr_ff[12].pc[63] ? 64'd0 - fr_ff[12].pc : fr_ff[12].pc;
      fr_in[13].pb    = fr_ff[12].pb[63] ? 64'd0 - fr_ff[12].pb : fr_ff[12].pb;
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      dv_seed       = '0;
      dv_seed.nq    = fr_ff[FR_N].pa;
      dv_seed.d     = fr_ff[FR_N].pb;
      dv_seed.neg   = fr_ff[FR_N].neg;
      dv_seed.fault = fr_ff[FR_N].fault;
      dv_seed.tout  = fr_ff[FR_N].tout;
      dv_seed.hum   = fr_ff[FR_N].hum;
      dv_in[1]      = div_step(dv_seed);
      for (int k = 2; k <= DV_N; k++) begin
         dv_in[k] = div_step(dv_ff[k-1]);
      end
   end

   // back: pressure correction terms
   always_comb begin
      bk_in[1]       = '0;
      bk_in[1].p     = dv_ff[DV_N].neg ? 64'd0 - dv_ff[DV_N].nq : dv_ff[DV_N].nq;
      bk_in[1].fault = dv_ff[DV_N].fault;
      bk_in[1].tout  = dv_ff[DV_N].tout;
      bk_in[1].hum   = dv_ff[DV_N].hum;

      bk_in[2]      = bk_ff[1];
      bk_in[2].pl_a = mul_pp(asr64(bk_ff[1].p, 13), asr64(bk_ff[1].p, 13));
      bk_in[2].pl_b = mul_pp(p8_c, bk_ff[1].p);

      bk_in[3]    = bk_ff[2];
      bk_in[3].pa = mul_sum(bk_ff[2].pl_a);
      bk_in[3].pb = asr64(mul_sum(bk_ff[2].pl_b), 19);

      bk_in[4]      = bk_ff[3];
      bk_in[4].pl_a = mul_pp(p9_c, bk_ff[3].pa);

      bk_in[5]    = bk_ff[4];
      bk_in[5].pa = asr64(mul_sum(bk_ff[4].pl_a), 25);

      bk_in[6]    = bk_ff[5];
      bk_in[6].pa = bk_ff[5].p + bk_ff[5].pa + bk_ff[5].pb;

      pf_w                  = asr64(bk_ff[BK_N].pa, 8) + (p7_c << 4);
      hval_w                = humidity_present_ff & ~bk_ff[BK_N].fault;
      out_in.temperature    = bk_ff[BK_N].tout;
      out_in.pressure       = bk_ff[BK_N].fault ? '0 : 32'(asr64(pf_w, 8));
      out_in.humidity       = hval_w ? bk_ff[BK_N].hum : '0;
      out_in.humidity_valid = hval_w;
      out_in.fault          = bk_ff[BK_N].fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff         <= 1'b0;
         pipe_vld_ff         <= '0;
         cal_temp_ff         <= '0;
         cal_press_a_ff      <= '0;
         cal_press_b_ff      <= '0;
         cal_press_c_ff      <= '0;
         cal_hum_a_ff        <= '0;
         cal_hum_b_ff        <= '0;
         temp_offset_ff      <= '0;
         humidity_present_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_CAL_TEMP:    cal_temp_ff         <= csr_ch.data;
               CSR_CAL_PRESS_A: cal_press_a_ff      <= csr_ch.data;
               CSR_CAL_PRESS_B: cal_press_b_ff      <= csr_ch.data;
               CSR_CAL_PRESS_C: cal_press_c_ff      <= csr_ch.data;
               CSR_CAL_HUM_A:   cal_hum_a_ff        <= csr_ch.data[31:0];
               CSR_CAL_HUM_B:   cal_hum_b_ff        <= csr_ch.data[31:0];
               CSR_TEMP_OFFSET: temp_offset_ff      <= csr_ch.data[15:0];
               CSR_HUM_PRESENT: humidity_present_ff <= csr_ch.data[0];
               default: ;
            endcase
         end
         if (adv) begin
            pipe_vld_ff <= pipe_vld_in;
            skid_vld_ff <= 1'b0;
         end else if (req_ch.valid && !skid_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_p_ff <= req_ch.raw_pressure;
         skid_t_ff <= req_ch.raw_temperature;
         skid_h_ff <= req_ch.raw_humidity;
      end
      if (adv) begin
         fr_ff  <= fr_in;
         dv_ff  <= dv_in;
         bk_ff  <= bk_in;
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid          = pipe_vld_ff[NSTAGE-1];
   assign rsp_ch.temperature    = out_ff.temperature;
   assign rsp_ch.pressure       = out_ff.pressure;
   assign rsp_ch.humidity       = out_ff.humidity;
   assign rsp_ch.humidity_valid = out_ff.humidity_valid;
   assign rsp_ch.fault          = out_ff.fault;

   a_fault_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.fault |->
         rsp_ch.pressure == 32'd0 && !rsp_ch.humidity_valid && rsp_ch.humidity == 14'd0)
      else $error("fault beat carries pressure or humidity");

   a_hum_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.humidity_valid |->
         humidity_present_ff && rsp_ch.humidity <= 14'd10000)
      else $error("humidity out of range or not enabled");

   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && adv |=> !skid_vld_ff && pipe_vld_ff[0])
      else $error("skid beat lost");

endmodule
